// ----- rtl/kcs_hte_pkg.sv -----
`timescale 1ns / 1ps

package kcs_hte_pkg;

	localparam int FRAME_DEPTH = 64;
	localparam int LEN_W = $clog2(FRAME_DEPTH + 2);
	localparam int ADDR_W = $clog2(FRAME_DEPTH);

	localparam int MAX_RES = 3;
	localparam int NRES_W = $clog2(MAX_RES + 1);
	localparam int OQ_AW = 3;
	localparam int OQ_DEPTH = 1 << OQ_AW;
	localparam int OQ_CW = OQ_AW + 1;

	localparam int PADDR_W = 3;
	localparam logic REG_SPIN = 1'b0;
	localparam logic REG_CAP = 1'b1;

	localparam logic [31:0] SPIN_RESET = 32'd100000;
	localparam logic [15:0] CAP_RESET = 16'd64;

	localparam logic [1:0] OP_REQ = 2'd0;
	localparam logic [1:0] OP_STATUS = 2'd1;
	localparam logic [1:0] OP_DATA = 2'd2;

	localparam logic [2:0] ACT_READ_STATUS = 3'd0;
	localparam logic [2:0] ACT_READ_DATA = 3'd1;
	localparam logic [2:0] ACT_WRITE_CMD = 3'd2;
	localparam logic [2:0] ACT_WRITE_DATA = 3'd3;
	localparam logic [2:0] ACT_REPLY = 3'd4;
	localparam logic [2:0] ACT_DONE = 3'd5;

	localparam logic [2:0] STS_OK = 3'd0;
	localparam logic [2:0] STS_TIMEOUT = 3'd1;
	localparam logic [2:0] STS_NOT_READY = 3'd2;
	localparam logic [2:0] STS_DEV_ERR = 3'd3;
	localparam logic [2:0] STS_TRUNC = 3'd4;
	localparam logic [2:0] STS_SHORT = 3'd5;
	localparam logic [2:0] STS_BAD_REQ = 3'd6;

	localparam logic [1:0] KST_IDLE = 2'd0;
	localparam logic [1:0] KST_READ = 2'd1;
	localparam logic [1:0] KST_WRITE = 2'd2;
	localparam logic [1:0] KST_ERROR = 2'd3;

	localparam logic [7:0] CTL_WSTART = 8'h61;
	localparam logic [7:0] CTL_WEND = 8'h62;
	localparam logic [7:0] CTL_READ = 8'h68;
	localparam logic [15:0] MIN_REPLY = 16'd3;

	typedef enum logic [3:0] {
		PH_COLLECT,
		PH_ACQ,
		PH_FLA_S,
		PH_FLA_D,
		PH_W_IBF,
		PH_W_CHK,
		PH_FLW_S,
		PH_FLW_D,
		PH_W_FIN,
		PH_R_STATE,
		PH_R_OBF,
		PH_R_DATA,
		PH_R_IBF,
		PH_FLR_S,
		PH_FLR_D
	} phase_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  byte_res;
		logic [2:0]  status_code;
		logic [15:0] count;
		logic        end_of_run;
	} result_t;

	function automatic result_t mk_res(input logic [2:0] act, input logic [7:0] b,
			input logic [2:0] code, input logic [15:0] cnt);
		result_t r;
		r.action = act;
		r.byte_res = b;
		r.status_code = code;
		r.count = cnt;
		r.end_of_run = 1'b0;
		return r;
	endfunction

endpackage

// ----- rtl/kcs_hte_ram.sv -----
`timescale 1ns / 1ps

module kcs_hte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/kcs_hte_outq.sv -----
`timescale 1ns / 1ps

module kcs_hte_outq import kcs_hte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [NRES_W-1:0] push_n,
	input  result_t           push_res [MAX_RES],
	output logic              room,
	output logic              head_valid,
	output result_t           head_res,
	input  logic              pop
);

	result_t ent_q [OQ_DEPTH];
	logic [OQ_AW-1:0] head_q;
	logic [OQ_AW-1:0] tail_q;
	logic [OQ_CW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (NRES_W'(i) < push_n) begin
				ent_q[tail_q + OQ_AW'(i)] <= push_res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
		end else begin
			head_q <= head_q + OQ_AW'(pop);
			tail_q <= tail_q + OQ_AW'(push_n);
			cnt_q <= cnt_q + OQ_CW'(push_n) - OQ_CW'(pop);
		end
	end

	assign room = cnt_q <= OQ_CW'(OQ_DEPTH - MAX_RES);
	assign head_valid = cnt_q != '0;
	assign head_res = ent_q[head_q];

endmodule

// ----- rtl/kcs_host_transaction_engine_core.sv -----
`timescale 1ns / 1ps
// the results of an accepted request item are registered in the result queue before they are offered
// results leave one per cycle while res_stall is low; the k results of one request item leave in order
// throughput: one request item per cycle while the 8-entry result queue has room for three
// request bytes sit in a 64-entry ram, prefetched at the write position for the write phase
// reset clears phase and counters, loads spin_limit 100000 and reply_capacity 64

module kcs_host_transaction_engine_core import kcs_hte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         op,
	input  logic [7:0]         value,
	input  logic               last,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [2:0]         action,
	output logic [7:0]         byte_res,
	output logic [2:0]         status_code,
	output logic [15:0]        count,
	output logic               end_of_run
);

	logic [31:0] spin_q;
	logic [15:0] cap_q;

	phase_t phase_q, phase_d;
	logic [31:0] poll_q, poll_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] wpos_q, wpos_d;
	logic [15:0] rcnt_q, rcnt_d;
	logic ovf_q, ovf_d;
	logic fin;

	logic mem_we;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0] rd_data;

	logic acc, step, want_data, op_ok, room;
	logic ibf, obf;
	logic [1:0] kst;
	logic [31:0] lim, poll_inc;
	logic poll_exp;
	logic [LEN_W-1:0] len_inc, len_n, len_m1, wpos_inc;
	logic wpos_end, wpos_past;
	logic [15:0] rcnt_inc;
	logic [2:0] flush_code;

	result_t res [MAX_RES];
	logic [NRES_W-1:0] n_res;
	result_t head_res;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CAP) ? {16'b0, cap_q} : spin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_q <= SPIN_RESET;
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_CAP) begin
				cap_q <= pwdata[15:0];
			end else begin
				spin_q <= pwdata;
			end
		end
	end

	// transaction decode
	assign req_stall = !room;
	assign acc = req_valid && !req_stall;
	assign want_data = phase_q == PH_FLA_D || phase_q == PH_FLW_D ||
		phase_q == PH_FLR_D || phase_q == PH_R_DATA;
	assign op_ok = (phase_q == PH_COLLECT) ? (op == OP_REQ) :
		(op == (want_data ? OP_DATA : OP_STATUS));
	assign step = acc && op_ok;

	assign obf = value[0];
	assign ibf = value[1];
	assign kst = value[7:6];

	assign lim = (spin_q == '0) ? 32'd1 : spin_q;
	assign poll_inc = (poll_q == '1) ? poll_q : poll_q + 32'd1;
	assign poll_exp = poll_inc >= lim;

	assign len_inc = len_q + 1'b1;
	assign len_n = (len_q < LEN_W'(FRAME_DEPTH)) ? len_inc : LEN_W'(FRAME_DEPTH + 1);
	assign len_m1 = len_q - 1'b1;
	assign wpos_inc = wpos_q + 1'b1;
	assign wpos_end = wpos_inc == len_q;
	assign wpos_past = wpos_inc > len_q;
	assign rcnt_inc = (rcnt_q == '1) ? rcnt_q : rcnt_q + 16'd1;
	assign flush_code = (rcnt_q < MIN_REPLY) ? STS_SHORT : (ovf_q ? STS_TRUNC : STS_OK);

	// the byte the next data write needs, ready long before the flush that issues it
	assign rd_addr = (wpos_q < len_q) ? wpos_q[ADDR_W-1:0] : len_m1[ADDR_W-1:0];

	kcs_hte_ram #(
		.WIDTH(8),
		.DEPTH(FRAME_DEPTH)
	) u_req_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(len_q[ADDR_W-1:0]),
		.wdata(value),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// next state
	always_comb begin
		phase_d = phase_q;
		poll_d = poll_q;
		len_d = len_q;
		wpos_d = wpos_q;
		rcnt_d = rcnt_q;
		ovf_d = ovf_q;
		mem_we = 1'b0;
		fin = 1'b0;
		if (step) begin
			unique case (phase_q)
				PH_COLLECT: begin
					mem_we = len_q < LEN_W'(FRAME_DEPTH);
					len_d = len_n;
					if (last) begin
						if (len_n < LEN_W'(2) || len_n > LEN_W'(FRAME_DEPTH)) begin
							fin = 1'b1;
						end else begin
							rcnt_d = '0;
							ovf_d = 1'b0;
							phase_d = PH_ACQ;
							poll_d = '0;
						end
					end
				end
				PH_ACQ: begin
					if (!ibf && kst == KST_IDLE) begin
						phase_d = PH_FLA_S;
						poll_d = '0;
					end else if (poll_exp) begin
						fin = 1'b1;
					end else begin
						poll_d = poll_inc;
					end
				end
				PH_FLA_S, PH_FLA_D: begin
					if (phase_q == PH_FLA_S && obf) begin
						phase_d = PH_FLA_D;
					end else begin
						wpos_d = '0;
						phase_d = PH_W_IBF;
						poll_d = '0;
					end
				end
				PH_FLW_S, PH_FLW_D: begin
					if (phase_q == PH_FLW_S && obf) begin
						phase_d = PH_FLW_D;
					end else begin
						wpos_d = wpos_inc;
						phase_d = wpos_past ? PH_W_FIN : PH_W_IBF;
						poll_d = '0;
					end
				end
				PH_FLR_S, PH_FLR_D: begin
					if (phase_q == PH_FLR_S && obf) begin
						phase_d = PH_FLR_D;
					end else begin
						fin = 1'b1;
					end
				end
				PH_W_IBF: begin
					if (!ibf) begin
						phase_d = PH_W_CHK;
						poll_d = '0;
					end else if (poll_exp) begin
						fin = 1'b1;
					end else begin
						poll_d = poll_inc;
					end
				end
				PH_W_CHK: begin
					if (kst != KST_WRITE) begin
						fin = 1'b1;
					end else begin
						phase_d = PH_FLW_S;
						poll_d = '0;
					end
				end
				PH_W_FIN, PH_R_IBF: begin
					if (!ibf) begin
						phase_d = PH_R_STATE;
						poll_d = '0;
					end else if (poll_exp) begin
						fin = 1'b1;
					end else begin
						poll_d = poll_inc;
					end
				end
				PH_R_STATE: begin
					if (kst == KST_READ) begin
						phase_d = PH_R_OBF;
						poll_d = '0;
					end else if (kst == KST_IDLE) begin
						phase_d = PH_FLR_S;
						poll_d = '0;
					end else if (kst == KST_ERROR || poll_exp) begin
						fin = 1'b1;
					end else begin
						poll_d = poll_inc;
					end
				end
				PH_R_OBF: begin
					if (obf) begin
						phase_d = PH_R_DATA;
					end else if (poll_exp) begin
						fin = 1'b1;
					end else begin
						poll_d = poll_inc;
					end
				end
				PH_R_DATA: begin
					if (rcnt_q >= cap_q) begin
						ovf_d = 1'b1;
					end
					rcnt_d = rcnt_inc;
					phase_d = PH_R_IBF;
					poll_d = '0;
				end
				default: begin
					phase_d = PH_COLLECT;
				end
			endcase
			if (fin) begin
				phase_d = PH_COLLECT;
				poll_d = '0;
				len_d = '0;
				wpos_d = '0;
				rcnt_d = '0;
				ovf_d = 1'b0;
			end
		end
	end

	// results
	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			res[i] = '0;
		end
		n_res = '0;
		if (step) begin
			unique case (phase_q)
				PH_COLLECT: begin
					if (last) begin
						n_res = NRES_W'(1);
						if (len_n < LEN_W'(2) || len_n > LEN_W'(FRAME_DEPTH)) begin
							res[0] = mk_res(ACT_DONE, 8'd0, STS_BAD_REQ, rcnt_q);
						end else begin
							res[0] = mk_res(ACT_READ_STATUS, 8'd0, STS_OK, 16'd0);
						end
					end
				end
				PH_ACQ: begin
					n_res = NRES_W'(1);
					if ((ibf || kst != KST_IDLE) && poll_exp) begin
						res[0] = mk_res(ACT_DONE, 8'd0, STS_NOT_READY, rcnt_q);
					end else begin
						res[0] = mk_res(ACT_READ_STATUS, 8'd0, STS_OK, 16'd0);
					end
				end
				PH_FLA_S, PH_FLA_D: begin
					if (phase_q == PH_FLA_S && obf) begin
						n_res = NRES_W'(1);
						res[0] = mk_res(ACT_READ_DATA, 8'd0, STS_OK, 16'd0);
					end else begin
						n_res = NRES_W'(2);
						res[0] = mk_res(ACT_WRITE_CMD, CTL_WSTART, STS_OK, 16'd0);
						res[1] = mk_res(ACT_READ_STATUS, 8'd0, STS_OK, 16'd0);
					end
				end
				PH_FLW_S, PH_FLW_D: begin
					if (phase_q == PH_FLW_S && obf) begin
						n_res = NRES_W'(1);
						res[0] = mk_res(ACT_READ_DATA, 8'd0, STS_OK, 16'd0);
					end else begin
						n_res = NRES_W'(2);
						if (wpos_end) begin
							res[0] = mk_res(ACT_WRITE_CMD, CTL_WEND, STS_OK, 16'd0);
						end else begin
							res[0] = mk_res(ACT_WRITE_DATA, rd_data, STS_OK, 16'd0);
						end
						res[1] = mk_res(ACT_READ_STATUS, 8'd0, STS_OK, 16'd0);
					end
				end
				PH_FLR_S, PH_FLR_D: begin
					n_res = NRES_W'(1);
					if (phase_q == PH_FLR_S && obf) begin
						res[0] = mk_res(ACT_READ_DATA, 8'd0, STS_OK, 16'd0);
					end else begin
						res[0] = mk_res(ACT_DONE, 8'd0, flush_code, rcnt_q);
					end
				end
				PH_W_IBF, PH_W_FIN, PH_R_IBF: begin
					n_res = NRES_W'(1);
					if (ibf && poll_exp) begin
						res[0] = mk_res(ACT_DONE, 8'd0, STS_TIMEOUT, rcnt_q);
					end else begin
						res[0] = mk_res(ACT_READ_STATUS, 8'd0, STS_OK, 16'd0);
					end
				end
				PH_W_CHK: begin
					n_res = NRES_W'(1);
					if (kst != KST_WRITE) begin
						res[0] = mk_res(ACT_DONE, 8'd0, STS_DEV_ERR, rcnt_q);
					end else begin
						res[0] = mk_res(ACT_READ_STATUS, 8'd0, STS_OK, 16'd0);
					end
				end
				PH_R_STATE: begin
					n_res = NRES_W'(1);
					if (kst == KST_ERROR) begin
						res[0] = mk_res(ACT_DONE, 8'd0, STS_DEV_ERR, rcnt_q);
					end else if (kst == KST_WRITE && poll_exp) begin
						res[0] = mk_res(ACT_DONE, 8'd0, STS_TIMEOUT, rcnt_q);
					end else begin
						res[0] = mk_res(ACT_READ_STATUS, 8'd0, STS_OK, 16'd0);
					end
				end
				PH_R_OBF: begin
					n_res = NRES_W'(1);
					if (obf) begin
						res[0] = mk_res(ACT_READ_DATA, 8'd0, STS_OK, 16'd0);
					end else if (poll_exp) begin
						res[0] = mk_res(ACT_DONE, 8'd0, STS_TIMEOUT, rcnt_q);
					end else begin
						res[0] = mk_res(ACT_READ_STATUS, 8'd0, STS_OK, 16'd0);
					end
				end
				PH_R_DATA: begin
					if (rcnt_q < cap_q) begin
						n_res = NRES_W'(3);
						res[0] = mk_res(ACT_REPLY, value, STS_OK, 16'd0);
						res[1] = mk_res(ACT_WRITE_DATA, CTL_READ, STS_OK, 16'd0);
						res[2] = mk_res(ACT_READ_STATUS, 8'd0, STS_OK, 16'd0);
					end else begin
						n_res = NRES_W'(2);
						res[0] = mk_res(ACT_WRITE_DATA, CTL_READ, STS_OK, 16'd0);
						res[1] = mk_res(ACT_READ_STATUS, 8'd0, STS_OK, 16'd0);
					end
				end
				default: begin
					n_res = '0;
				end
			endcase
		end
		for (int i = 0; i < MAX_RES; i++) begin
			res[i].end_of_run = (n_res != '0) && (NRES_W'(i) == n_res - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COLLECT;
			poll_q <= '0;
			len_q <= '0;
			wpos_q <= '0;
			rcnt_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			poll_q <= poll_d;
			len_q <= len_d;
			wpos_q <= wpos_d;
			rcnt_q <= rcnt_d;
			ovf_q <= ovf_d;
		end
	end

	kcs_hte_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push_n(n_res),
		.push_res(res),
		.room(room),
		.head_valid(res_valid),
		.head_res(head_res),
		.pop(res_valid && !res_stall)
	);

	assign action = head_res.action;
	assign byte_res = head_res.byte_res;
	assign status_code = head_res.status_code;
	assign count = head_res.count;
	assign end_of_run = head_res.end_of_run;

`ifndef SYNTHESIS
	// prefetched request byte must have settled before a write-phase flush uses it
	a_prefetch_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(step && (phase_q == PH_FLW_S || phase_q == PH_FLW_D)) |-> rd_addr == $past(rd_addr))
		else $error("request byte read address moved just before a data write");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && fin) |=> (phase_q == PH_COLLECT && len_q == '0 && rcnt_q == '0 && !ovf_q))
		else $error("engine not back to collecting after done");

	// the final byte leaves the position one past the request length
	a_wpos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_COLLECT) |-> wpos_q <= len_inc)
		else $error("write position beyond request length");
`endif

endmodule
